>>> rtl/byte_stuffed_frame_receiver_top_defines.svh
// Assertion macros used by the frame receiver control block.
`ifndef BYTE_STUFFED_FRAME_RECEIVER_TOP_DEFINES_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define BSFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define BSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bsfr_pkg.sv
// Package: constants, register indexes and state type of the frame receiver.
`default_nettype none
package bsfr_pkg;

    localparam int unsigned PACKET_BYTES_DEF = 64;
    localparam int unsigned BYTE_W           = 8;
    localparam int unsigned CFG_INDEX_W      = 2;

    localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'hDD;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7D;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FLAG   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

endpackage
`default_nettype wire

>>> rtl/bsfr_if.sv
// Valid/ready channel interfaces for received bytes and packet results.
`default_nettype none
interface bsfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    logic       empty_packet;

    modport source (output valid, output data_byte, output last, output empty_packet,
                    input ready);
    modport sink   (input valid, input data_byte, input last, input empty_packet,
                    output ready);
endinterface
`default_nettype wire

>>> rtl/byte_stuffed_frame_receiver_top.sv
// Top level of the byte-stuffed frame receiver.
// Each accepted byte is decoded combinationally against the flag and escape registers and, when it
// is payload, written to the packet store at the running count, so the receiver takes one byte
// per cycle while filling. An unescaped flag closes the packet: a packet of n stored bytes
// yields n-1 results streamed from the store's registered read port at one per cycle while the
// output is taken (a single-byte packet yields one empty-packet result), and no byte is
// accepted until the final result of the run sits in the output register. The store needs no
// clearing after reset.
`default_nettype none
module byte_stuffed_frame_receiver_top #(
    parameter int unsigned PACKET_BYTES = bsfr_pkg::PACKET_BYTES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bsfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]      cfg_wdata,
    bsfr_in_if.sink                               in_ch,
    bsfr_out_if.source                            out_ch
);
    import bsfr_pkg::*;

    localparam int unsigned AW = $clog2(PACKET_BYTES);

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;

    bsfr_ctrl #(
        .PACKET_BYTES (PACKET_BYTES),
        .AW           (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    bsfr_store #(
        .DEPTH (PACKET_BYTES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
`default_nettype wire

>>> rtl/bsfr_store.sv
// Packet store: single-port-write, registered-read byte memory.
`default_nettype none
module bsfr_store #(
    parameter int unsigned DEPTH = bsfr_pkg::PACKET_BYTES_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]  wr_data,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                rd_addr,
    output      logic [bsfr_pkg::BYTE_W-1:0]  rd_data
);
    import bsfr_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> rtl/bsfr_ctrl.sv
// Control: escape decoding, byte count, store addressing and packet drain.
`default_nettype none
`include "byte_stuffed_frame_receiver_top_defines.svh"
module bsfr_ctrl #(
    parameter int unsigned PACKET_BYTES = bsfr_pkg::PACKET_BYTES_DEF,
    parameter int unsigned AW           = $clog2(PACKET_BYTES)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [bsfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]     cfg_wdata,
    bsfr_in_if.sink                              in_ch,
    bsfr_out_if.source                           out_ch,
    output      logic                            wr_en,
    output      logic [AW-1:0]                   wr_addr,
    output      logic [bsfr_pkg::BYTE_W-1:0]     wr_data,
    output      logic                            rd_en,
    output      logic [AW-1:0]                   rd_addr,
    input  wire logic [bsfr_pkg::BYTE_W-1:0]     rd_data
);
    import bsfr_pkg::*;

    localparam logic [AW-1:0] CNT_MAX = AW'(PACKET_BYTES - 1);

    state_t            state_reg, state_next;
    logic [AW-1:0]     count_reg, count_next;
    logic              esc_reg, esc_next;
    logic [BYTE_W-1:0] flag_reg, flag_next;
    logic [BYTE_W-1:0] escape_reg, escape_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     last_idx_reg, last_idx_next;
    logic              empty_reg, empty_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              out_empty_reg, out_empty_next;

    logic in_fire, is_flag, is_esc;
    logic do_close, do_store, set_esc;
    logic out_free, load_out, at_last;

    // Input decode
    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign is_flag     = (in_ch.rx_byte == flag_reg);
    assign is_esc      = (in_ch.rx_byte == escape_reg);
    assign do_close    = in_fire && is_flag && !esc_reg;
    assign do_store    = in_fire && ((is_flag && esc_reg) || (!is_flag && (!is_esc || esc_reg)));
    assign set_esc     = in_fire && !is_flag && is_esc && !esc_reg;

    // Drain handshake: the output register frees when empty or taken
    assign out_free = !out_valid_reg || out_ch.ready;
    assign at_last  = empty_reg || (idx_reg == last_idx_reg);
    assign load_out = (state_reg == S_DRAIN) && out_free;

    // Store access; a stored byte is visible to reads issued after its write
    assign wr_en   = do_store;
    assign wr_addr = count_reg;
    assign wr_data = in_ch.rx_byte;
    assign rd_en   = (do_close && (count_reg > AW'(1)))
                  || (load_out && !at_last);
    assign rd_addr = (state_reg == S_IDLE) ? '0 : AW'(idx_reg + 1'b1);

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        esc_next       = esc_reg;
        idx_next       = idx_reg;
        last_idx_next  = last_idx_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        flag_next      = (cfg_wr_en && cfg_index == REG_FLAG) ? cfg_wdata : flag_reg;
        escape_next    = (cfg_wr_en && cfg_index == REG_ESCAPE) ? cfg_wdata : escape_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (do_store)
                begin
                    count_next = (count_reg == CNT_MAX) ? '0 : AW'(count_reg + 1'b1);
                    esc_next   = 1'b0;
                end
                else if (set_esc)
                begin
                    esc_next = 1'b1;
                end
                else if (do_close)
                begin
                    count_next    = '0;
                    idx_next      = '0;
                    last_idx_next = AW'(count_reg - AW'(2));
                    empty_next    = (count_reg == AW'(1));
                    if (count_reg != '0)
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = empty_reg ? '0 : rd_data;
                    out_last_next  = at_last;
                    out_empty_next = empty_reg;
                    if (at_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = AW'(idx_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            esc_reg       <= 1'b0;
            flag_reg      <= FLAG_RESET;
            escape_reg    <= ESCAPE_RESET;
            idx_reg       <= '0;
            last_idx_reg  <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            esc_reg       <= esc_next;
            flag_reg      <= flag_next;
            escape_reg    <= escape_next;
            idx_reg       <= idx_next;
            last_idx_reg  <= last_idx_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.data_byte    = out_data_reg;
    assign out_ch.last         = out_last_reg;
    assign out_ch.empty_packet = out_empty_reg;

    // Checks
    `BSFR_ASSERT_NOW(a_no_write_in_drain, state_reg == S_DRAIN, !wr_en, "store written during drain")
    `BSFR_ASSERT_NEXT(a_close_clears_count, do_close, count_reg == '0, "count not cleared on close")
    `BSFR_ASSERT_NEXT(a_last_ends_drain, load_out && at_last, state_reg == S_IDLE, "drain did not end")
    `BSFR_ASSERT_NOW(a_idx_bounded, state_reg == S_DRAIN && !empty_reg, idx_reg <= last_idx_reg, "drain index past end")

endmodule
`default_nettype wire
